// ===== sv/psr_pkg.sv =====
// Shared types, constants and default parameter values for the stereo resampler.
package psr_pkg;

    localparam int DEF_MAX_LOG2_PHASES      = 5;
    localparam int DEF_MAX_TAPS             = 64;
    localparam int DEF_INTERP_FRACTION_BITS = 8;
    localparam int DEF_FRAME_DEPTH          = 4096;

    localparam int DITHER_SHIFT = 10;
    localparam int COEF_FRAC    = 22;

    typedef enum logic [1:0] {
        MODE_COEF  = 2'd0,
        MODE_FRAME = 2'd1,
        MODE_RUN   = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_STEP_SIZE   = 3'd0,
        REG_START_POS   = 3'd1,
        REG_DITHER_SEED = 3'd2,
        REG_LOG2_PHASES = 3'd3,
        REG_TAP_GROUPS  = 3'd4,
        REG_INPUT_FRAMES = 3'd5,
        REG_LCG_MULT    = 3'd6,
        REG_LCG_INC     = 3'd7
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_BASE,
        ST_TAP,
        ST_MUL0,
        ST_MUL1,
        ST_SUM,
        ST_MULL,
        ST_MULR,
        ST_ACCR,
        ST_DL0,
        ST_DL1,
        ST_DL2,
        ST_DL3
    } state_t;

endpackage

// ===== sv/polyphase_stereo_resampler_unit.sv =====
// Polyphase stereo resampler with one shared 32x32 multiplier under a sequencer.
// Load requests (coefficient or frame) write their store directly; busy stays low.
// An output request runs SETUP, BASE, per tap a TAP step plus, for a tap inside the input,
// MUL0, MUL1, SUM, MULL, MULR and ACCR (four uses of the shared multiplier), then DL0 to DL3;
// the result strobe is registered from DL3, and the receiver cannot stall it.
// Reset clears control and configuration registers to defaults; the stores stay undefined until written.
module polyphase_stereo_resampler_unit #(
    parameter int MAX_LOG2_PHASES      = psr_pkg::DEF_MAX_LOG2_PHASES,
    parameter int MAX_TAPS             = psr_pkg::DEF_MAX_TAPS,
    parameter int INTERP_FRACTION_BITS = psr_pkg::DEF_INTERP_FRACTION_BITS,
    parameter int FRAME_DEPTH          = psr_pkg::DEF_FRAME_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         mode,
    input  logic [11:0]        coef_index,
    input  logic signed [23:0] coef_value,
    input  logic [11:0]        frame_index,
    input  logic signed [15:0] left_in,
    input  logic signed [15:0] right_in,
    output logic               result_valid,
    output logic signed [15:0] left_out,
    output logic signed [15:0] right_out,
    output logic signed [31:0] frame_position,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data
);
    import psr_pkg::*;

    localparam int COEF_DEPTH = ((1 << MAX_LOG2_PHASES) + 1) * MAX_TAPS;
    localparam int CA_W = $clog2(COEF_DEPTH);
    localparam int FA_W = $clog2(FRAME_DEPTH);
    localparam int NW   = $clog2(FRAME_DEPTH + 1);
    localparam int JW   = $clog2(MAX_TAPS + 1);
    localparam int RW   = (MAX_LOG2_PHASES > 0) ? MAX_LOG2_PHASES : 1;
    localparam int WW   = INTERP_FRACTION_BITS + 1;
    localparam int MAX_GROUPS = MAX_TAPS / 8;

    logic [23:0] coef_mem [COEF_DEPTH];
    logic [31:0] frame_mem [FRAME_DEPTH];

    state_t state_reg, state_next;

    logic [62:0] step_size_reg;
    logic [2:0]  log2_phases_reg;
    logic [3:0]  tap_groups_reg;
    logic [12:0] input_frames_reg;
    logic [31:0] lcg_mult_reg;
    logic [31:0] lcg_inc_reg;
    logic [63:0] position_reg;
    logic [31:0] dither_reg;

    logic [RW-1:0]      row_reg;
    logic [WW-1:0]      w0_reg, w1_reg;
    logic [JW-1:0]      ntaps_reg, j_reg;
    logic [NW-1:0]      nin_reg;
    logic signed [31:0] off_reg;
    logic [CA_W-1:0]    base0_reg, base1_reg;
    logic signed [23:0] c0_rd, c1_rd;
    logic [31:0]        fr_rd;
    logic signed [63:0] prod_reg;
    logic signed [63:0] blend_reg;
    logic signed [31:0] b_reg;
    logic signed [55:0] accl_reg, accr_reg;
    logic [31:0]        s1_reg;
    logic signed [15:0] left_pend_reg;
    logic               done_reg;
    logic signed [15:0] left_out_reg, right_out_reg;
    logic signed [31:0] frame_pos_reg;

    logic               accept;
    logic               cfg_wr;
    logic [3:0]         lp;
    logic [31:0]        frac;
    logic [RW-1:0]      row_calc;
    logic [WW-1:0]      w1_calc;
    logic [JW-1:0]      ntaps_calc;
    logic [NW-1:0]      nin_calc;
    logic signed [32:0] idx;
    logic               idx_in;
    logic               taps_done;
    logic signed [31:0] mul_a, mul_b;
    logic [31:0]        lcg_val;
    logic signed [63:0] blend_sum;

    // Adds the dither, floors to an integer and saturates to 16 bits.
    function automatic logic signed [15:0] finish_sample(input logic signed [55:0] acc,
                                                         input logic [31:0] s);
        logic signed [55:0] sum;
        logic signed [33:0] v;
        begin
            sum = acc + $signed({34'd0, s[31:DITHER_SHIFT]});
            v = 34'(sum >>> COEF_FRAC);
            if (v > 34'sd32767) begin
                finish_sample = 16'sh7fff;
            end else if (v < -34'sd32768) begin
                finish_sample = -16'sh8000;
            end else begin
                finish_sample = v[15:0];
            end
        end
    endfunction

    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign busy      = (state_reg != ST_IDLE);

    assign result_valid   = done_reg;
    assign left_out       = left_out_reg;
    assign right_out      = right_out_reg;
    assign frame_position = frame_pos_reg;

    // Phase row and blend weight from the fraction of the running position; clamped tap and input-frame counts.
    always_comb
    begin
        lp = (int'(log2_phases_reg) > MAX_LOG2_PHASES) ? 4'(MAX_LOG2_PHASES)
                                                       : {1'b0, log2_phases_reg};
        frac = position_reg[31:0];
        if (lp == 4'd0) begin
            row_calc = '0;
        end else begin
            row_calc = RW'(frac >> (6'd32 - {2'b00, lp}));
        end
        w1_calc = {1'b0, INTERP_FRACTION_BITS'(frac >> (6'd32 - {2'b00, lp}
                                                 - 6'(INTERP_FRACTION_BITS)))};
        if (int'(tap_groups_reg) > MAX_GROUPS) begin
            ntaps_calc = JW'(MAX_GROUPS * 8);
        end else begin
            ntaps_calc = JW'({tap_groups_reg, 3'b000});
        end
        if (int'(input_frames_reg) > FRAME_DEPTH) begin
            nin_calc = NW'(FRAME_DEPTH);
        end else begin
            nin_calc = NW'(input_frames_reg);
        end
    end

    assign idx       = {off_reg[31], off_reg} + $signed({1'b0, 32'(j_reg)});
    assign idx_in    = !idx[32] && (idx < $signed({1'b0, 32'(nin_reg)}));
    assign taps_done = (j_reg == ntaps_reg);
    assign lcg_val   = prod_reg[31:0] + lcg_inc_reg;
    assign blend_sum = (blend_reg + prod_reg) >>> INTERP_FRACTION_BITS;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && mode == MODE_RUN) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: state_next = ST_BASE;
            ST_BASE:  state_next = ST_TAP;
            ST_TAP:
            begin
                if (taps_done) begin
                    state_next = ST_DL0;
                end else if (idx_in) begin
                    state_next = ST_MUL0;
                end
            end
            ST_MUL0: state_next = ST_MUL1;
            ST_MUL1: state_next = ST_SUM;
            ST_SUM:  state_next = ST_MULL;
            ST_MULL: state_next = ST_MULR;
            ST_MULR: state_next = ST_ACCR;
            ST_ACCR: state_next = ST_TAP;
            ST_DL0:  state_next = ST_DL1;
            ST_DL1:  state_next = ST_DL2;
            ST_DL2:  state_next = ST_DL3;
            ST_DL3:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_SETUP:
            begin
                mul_a = $signed(32'(row_reg));
                mul_b = $signed(32'(ntaps_reg));
            end
            ST_MUL0:
            begin
                mul_a = 32'(c0_rd);
                mul_b = $signed(32'(w0_reg));
            end
            ST_MUL1:
            begin
                mul_a = 32'(c1_rd);
                mul_b = $signed(32'(w1_reg));
            end
            ST_MULL:
            begin
                mul_a = b_reg;
                mul_b = 32'($signed(fr_rd[15:0]));
            end
            ST_MULR:
            begin
                mul_a = b_reg;
                mul_b = 32'($signed(fr_rd[31:16]));
            end
            ST_DL0:
            begin
                mul_a = dither_reg;
                mul_b = lcg_mult_reg;
            end
            ST_DL2:
            begin
                mul_a = s1_reg;
                mul_b = lcg_mult_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Control, configuration and result-strobe registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg        <= ST_IDLE;
            step_size_reg    <= 63'h1_0000_0000;
            log2_phases_reg  <= 3'd5;
            tap_groups_reg   <= 4'd8;
            input_frames_reg <= '0;
            lcg_mult_reg     <= 32'd1664525;
            lcg_inc_reg      <= 32'd1013904223;
            position_reg     <= '0;
            dither_reg       <= '0;
            done_reg         <= 1'b0;
            j_reg            <= '0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_DL3);
            if (cfg_wr) begin
                unique case (reg_index_t'(cfg_index))
                    REG_STEP_SIZE:    step_size_reg    <= cfg_data[62:0];
                    REG_START_POS:    position_reg     <= cfg_data;
                    REG_DITHER_SEED:  dither_reg       <= cfg_data[31:0];
                    REG_LOG2_PHASES:  log2_phases_reg  <= cfg_data[2:0];
                    REG_TAP_GROUPS:   tap_groups_reg   <= cfg_data[3:0];
                    REG_INPUT_FRAMES: input_frames_reg <= cfg_data[12:0];
                    REG_LCG_MULT:     lcg_mult_reg     <= cfg_data[31:0];
                    REG_LCG_INC:      lcg_inc_reg      <= cfg_data[31:0];
                    default:          lcg_inc_reg      <= lcg_inc_reg;
                endcase
            end
            if (state_reg == ST_BASE) begin
                j_reg <= '0;
            end else if ((state_reg == ST_TAP && !taps_done && !idx_in)
                         || state_reg == ST_ACCR) begin
                j_reg <= j_reg + 1'b1;
            end
            if (state_reg == ST_DL3) begin
                dither_reg   <= lcg_val;
                position_reg <= position_reg + {1'b0, step_size_reg};
            end
        end
    end

    // Datapath registers and the two stores.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (accept && mode == MODE_COEF && int'(coef_index) < COEF_DEPTH) begin
            coef_mem[CA_W'(coef_index)] <= coef_value;
        end
        if (accept && mode == MODE_FRAME && int'(frame_index) < FRAME_DEPTH) begin
            frame_mem[FA_W'(frame_index)] <= {right_in, left_in};
        end
        if (accept && mode == MODE_RUN) begin
            row_reg   <= row_calc;
            w1_reg    <= w1_calc;
            w0_reg    <= WW'(1 << INTERP_FRACTION_BITS) - w1_calc;
            ntaps_reg <= ntaps_calc;
            nin_reg   <= nin_calc;
            off_reg   <= position_reg[63:32];
            accl_reg  <= '0;
            accr_reg  <= '0;
        end
        if (state_reg == ST_BASE) begin
            base0_reg <= CA_W'(prod_reg);
            base1_reg <= CA_W'(prod_reg) + CA_W'(ntaps_reg);
        end
        if (state_reg == ST_TAP) begin
            c0_rd <= coef_mem[base0_reg + CA_W'(j_reg)];
            c1_rd <= coef_mem[base1_reg + CA_W'(j_reg)];
            fr_rd <= frame_mem[FA_W'(idx)];
        end
        if (state_reg == ST_MUL1) begin
            blend_reg <= prod_reg;
        end
        if (state_reg == ST_SUM) begin
            b_reg <= blend_sum[31:0];
        end
        if (state_reg == ST_MULR) begin
            accl_reg <= accl_reg + prod_reg[55:0];
        end
        if (state_reg == ST_ACCR) begin
            accr_reg <= accr_reg + prod_reg[55:0];
        end
        if (state_reg == ST_DL1) begin
            s1_reg        <= lcg_val;
            left_pend_reg <= finish_sample(accl_reg, dither_reg);
        end
        if (state_reg == ST_DL3) begin
            left_out_reg  <= left_pend_reg;
            right_out_reg <= finish_sample(accr_reg, s1_reg);
            frame_pos_reg <= position_reg[63:32];
        end
    end

endmodule

// ===== test/polyphase_stereo_resampler_unit_tb.sv =====
// Self-checking testbench for the polyphase stereo resampler unit.
`timescale 1ns / 1ps

module polyphase_stereo_resampler_unit_tb;
    import psr_pkg::*;

    localparam int COEF_DEPTH = 2112;
    localparam int NUM_FRAMES = 4096;

    typedef struct {
        mode_t       mode;
        logic [11:0] coef_index;
        logic [23:0] coef_value;
        logic [11:0] frame_index;
        logic [15:0] left_in;
        logic [15:0] right_in;
    } request_t;

    typedef struct {
        logic [15:0] left;
        logic [15:0] right;
        logic [31:0] pos;
    } out_frame_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] mode = 2'd0;
    logic [11:0] coef_index = '0;
    logic signed [23:0] coef_value = '0;
    logic [11:0] frame_index = '0;
    logic signed [15:0] left_in = '0;
    logic signed [15:0] right_in = '0;
    logic result_valid;
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic signed [31:0] frame_position;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [63:0] cfg_data = '0;

    always #5 clk = ~clk;

    polyphase_stereo_resampler_unit u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .coef_index(coef_index), .coef_value(coef_value), .frame_index(frame_index),
        .left_in(left_in), .right_in(right_in), .result_valid(result_valid),
        .left_out(left_out), .right_out(right_out), .frame_position(frame_position),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Predictor state and configuration.
    logic [62:0] m_step;
    logic [2:0]  m_log2_phases;
    logic [3:0]  m_tap_groups;
    logic [12:0] m_input_frames;
    logic [31:0] m_lcg_mult, m_lcg_inc;
    logic [63:0] m_position;
    logic [31:0] m_dither;
    logic signed [23:0] m_coefs [COEF_DEPTH];
    logic [31:0] m_frames [NUM_FRAMES];

    request_t   pending_requests [$];
    out_frame_t expected_frames [$];
    int  error_count = 0;
    bit  idle_enabled = 1'b1;
    int  gap_cycles = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic logic [15:0] saturate_sample(input logic signed [63:0] acc,
                                                    input logic [31:0] s);
        logic signed [63:0] v;
        v = (acc + $signed({42'd0, s[31:10]})) >>> COEF_FRAC;
        if (v > 64'sd32767) v = 64'sd32767;
        if (v < -64'sd32768) v = -64'sd32768;
        return v[15:0];
    endfunction

    function automatic logic [31:0] lcg_step(input logic [31:0] s);
        return s * m_lcg_mult + m_lcg_inc;
    endfunction

    task automatic resampler_predict(input request_t r);
        int lp, ntaps, nin, row, w1, w0, idx;
        logic signed [63:0] off, c0, c1, b, accl, accr;
        logic [31:0] frac, s;
        out_frame_t o;
        case (r.mode)
            MODE_COEF:
                if (r.coef_index < COEF_DEPTH) m_coefs[r.coef_index] = r.coef_value;
            MODE_FRAME:
                m_frames[r.frame_index] = {r.right_in, r.left_in};
            MODE_RUN:
            begin
                lp = (m_log2_phases > 5) ? 5 : m_log2_phases;
                ntaps = ((m_tap_groups > 8) ? 8 : m_tap_groups) * 8;
                nin = (m_input_frames > NUM_FRAMES) ? NUM_FRAMES : m_input_frames;
                frac = m_position[31:0];
                off = $signed({{32{m_position[63]}}, m_position[63:32]});
                row = ((frac >> 1) >> (31 - lp)) & ((1 << lp) - 1);
                w1 = (frac >> (32 - lp - 8)) & 8'hff;
                w0 = 256 - w1;
                accl = 0;
                accr = 0;
                for (int j = 0; j < ntaps; j++)
                begin
                    if (off + j >= 0 && off + j < nin)
                    begin
                        idx = int'(off + j);
                        c0 = m_coefs[row * ntaps + j];
                        c1 = m_coefs[(row + 1) * ntaps + j];
                        b = (c0 * w0 + c1 * w1) >>> 8;
                        accl += b * $signed(m_frames[idx][15:0]);
                        accr += b * $signed(m_frames[idx][31:16]);
                    end
                end
                s = m_dither;
                o.left = saturate_sample(accl, s);
                s = lcg_step(s);
                o.right = saturate_sample(accr, s);
                m_dither = lcg_step(s);
                o.pos = m_position[63:32];
                m_position += {1'b0, m_step};
                expected_frames.push_back(o);
            end
            default: ;
        endcase
    endtask

    // Driver: one request at a time, with random idle bursts.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                resampler_predict(pending_requests.pop_front());
            if (gap_cycles > 0)
            begin
                gap_cycles <= gap_cycles - 1;
                start <= 1'b0;
            end
            else if (!(start && busy))
            begin
                if (pending_requests.size() > 0
                    && !(idle_enabled && $urandom_range(0, 7) == 0))
                begin
                    request_t r;
                    r = pending_requests[0];
                    start <= 1'b1;
                    mode <= r.mode;
                    coef_index <= r.coef_index;
                    coef_value <= r.coef_value;
                    frame_index <= r.frame_index;
                    left_in <= r.left_in;
                    right_in <= r.right_in;
                end
                else
                begin
                    start <= 1'b0;
                    if (idle_enabled && $urandom_range(0, 3) == 0)
                        gap_cycles <= $urandom_range(1, 6) - 1;
                end
            end
        end
    end

    // Monitor.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (expected_frames.size() == 0)
            begin
                report_mismatch("unexpected result", frame_position, 32'd0);
            end
            else
            begin
                out_frame_t e;
                e = expected_frames.pop_front();
                if (left_out !== e.left)
                    report_mismatch("left_out", 32'(left_out), 32'(e.left));
                if (right_out !== e.right)
                    report_mismatch("right_out", 32'(right_out), 32'(e.right));
                if (frame_position !== e.pos)
                    report_mismatch("frame_position", frame_position, e.pos);
            end
        end
    end

    task automatic write_register(input reg_index_t idx, input logic [63:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_STEP_SIZE:    m_step = value[62:0];
            REG_START_POS:    m_position = value;
            REG_DITHER_SEED:  m_dither = value[31:0];
            REG_LOG2_PHASES:  m_log2_phases = value[2:0];
            REG_TAP_GROUPS:   m_tap_groups = value[3:0];
            REG_INPUT_FRAMES: m_input_frames = value[12:0];
            REG_LCG_MULT:     m_lcg_mult = value[31:0];
            default:          m_lcg_inc = value[31:0];
        endcase
    endtask

    task automatic wait_drained();
        while (pending_requests.size() != 0 || start || busy || expected_frames.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic queue_request(input mode_t m, input int ci, input int cv, input int fi,
                                 input int l, input int r);
        request_t q;
        q.mode = m;
        q.coef_index = 12'(ci);
        q.coef_value = 24'(cv);
        q.frame_index = 12'(fi);
        q.left_in = 16'(l);
        q.right_in = 16'(r);
        pending_requests.push_back(q);
    endtask

    // Loads the whole coefficient and frame stores so no unwritten entry is read.
    task automatic fill_stores(input int amp);
        for (int i = 0; i < COEF_DEPTH; i++)
            queue_request(MODE_COEF, i, $urandom_range(0, 1) ? $urandom % amp - amp / 2
                          : $urandom, 0, 0, 0);
        for (int i = 0; i < NUM_FRAMES; i++)
            queue_request(MODE_FRAME, 0, 0, i, $urandom, $urandom);
        wait_drained();
    endtask

    task automatic run_random_phase(input int count);
        int kind;
        for (int i = 0; i < count; i++)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 6)
                queue_request(MODE_RUN, $urandom, $urandom, $urandom, $urandom, $urandom);
            else if (kind < 8)
                queue_request(MODE_COEF, $urandom_range(0, 4095), $urandom, $urandom,
                              $urandom, $urandom);
            else if (kind < 9)
                queue_request(MODE_FRAME, $urandom, $urandom, $urandom, $urandom, $urandom);
            else
                queue_request(MODE_NONE, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
        wait_drained();
    endtask

    initial
    begin
        m_step = 63'h1_0000_0000;
        m_position = '0;
        m_dither = '0;
        m_log2_phases = 3'd5;
        m_tap_groups = 4'd8;
        m_input_frames = '0;
        m_lcg_mult = 32'd1664525;
        m_lcg_inc = 32'd1013904223;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        fill_stores(1 << 24);
        // Directed: extremes of the loads, no frames valid, then full-scale output.
        queue_request(MODE_COEF, 0, -8388608, 0, 0, 0);
        queue_request(MODE_COEF, 64, 8388607, 0, 0, 0);
        queue_request(MODE_COEF, 2111, 8388607, 0, 0, 0);
        queue_request(MODE_COEF, 4095, 1234, 0, 0, 0);
        queue_request(MODE_FRAME, 0, 0, 0, -32768, 32767);
        queue_request(MODE_FRAME, 0, 0, 4095, 32767, -32768);
        queue_request(MODE_NONE, 4095, -1, 4095, -1, -1);
        queue_request(MODE_RUN, 0, 0, 0, 0, 0);
        wait_drained();
        write_register(REG_INPUT_FRAMES, 64'd4096);
        write_register(REG_START_POS, 64'hffff_ffd0_8000_0000);
        write_register(REG_STEP_SIZE, 64'h0000_0007_4000_0000);
        for (int i = 0; i < 10; i++)
            queue_request(MODE_RUN, 0, 0, 0, 0, 0);
        wait_drained();
        // Clamped registers, zero taps, wrapping position and maximum step.
        write_register(REG_LOG2_PHASES, 64'd7);
        write_register(REG_TAP_GROUPS, 64'd15);
        write_register(REG_INPUT_FRAMES, 64'd8191);
        write_register(REG_START_POS, 64'h0000_0ff8_ffff_ffff);
        write_register(REG_STEP_SIZE, 64'h7fff_ffff_ffff_ffff);
        write_register(REG_DITHER_SEED, 64'hffff_ffff);
        write_register(REG_LCG_MULT, 64'hffff_ffff);
        write_register(REG_LCG_INC, 64'hffff_ffff);
        for (int i = 0; i < 4; i++)
            queue_request(MODE_RUN, 0, 0, 0, 0, 0);
        wait_drained();
        write_register(REG_TAP_GROUPS, 64'd0);
        write_register(REG_LOG2_PHASES, 64'd0);
        queue_request(MODE_RUN, 0, 0, 0, 0, 0);
        wait_drained();

        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph == 5) idle_enabled = 1'b0;
            write_register(REG_LOG2_PHASES, $urandom_range(0, 7));
            write_register(REG_TAP_GROUPS, $urandom_range(0, 3) == 0 ? $urandom_range(0, 15)
                           : $urandom_range(1, 2));
            write_register(REG_INPUT_FRAMES, $urandom_range(0, 8191));
            write_register(REG_START_POS, {$urandom_range(0, 1) ? $urandom
                           : 32'($urandom_range(0, 4200)) - 32'd40, $urandom});
            write_register(REG_STEP_SIZE, {1'b0, 31'($urandom_range(0, 3) == 0 ? $urandom
                           : $urandom_range(0, 3)), $urandom});
            write_register(REG_DITHER_SEED, $urandom);
            write_register(REG_LCG_MULT, $urandom_range(0, 1) ? 32'd1664525 : $urandom);
            write_register(REG_LCG_INC, $urandom);
            run_random_phase(300);
        end
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
